// File: rtl/pcdm_pkg.sv
// pcdm_pkg: widths, constants and sequencer codes for the PWM duty meter.
// No dependencies; used by pwm_capture_duty_meter and pcdm_checker.
`timescale 1ns / 1ps

package pcdm_pkg;

	localparam int CAP_W  = 16;
	localparam int DUTY_W = 8;
	localparam int REM_W  = 23;   // on_ticks * 100 fits in 23 bits
	localparam int DIV_W  = CAP_W + DUTY_W;
	localparam int CNT_W  = 4;

	localparam logic [6:0]        DUTY_SCALE = 7'd100;
	localparam logic [DUTY_W-1:0] DUTY_MAX   = 8'd255;
	localparam logic [CNT_W-1:0]  SAT_STEP   = 4'd8;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_FALL   = 2'd2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

endpackage

// File: rtl/pwm_capture_duty_meter.sv
// PWM period / on-time / duty meter from timer capture stamps.
// Rising-edge words go straight to the done state; falling-edge words pass the multiply
// and divide states, leaving divide early if duty saturates on the first step and
// skipping it on a zero period. No new word is taken until the last has left; the shared
// compare-subtract unit runs one saturation step and eight quotient steps per duty value.
// Reset (arst_n low, asynchronous): phase 0, stamps and period cleared, no word out.
`timescale 1ns / 1ps

module pwm_capture_duty_meter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pcdm_pkg::CAP_W-1:0]  capture_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        next_edge_falling,
	output logic                        measurement_valid,
	output logic [pcdm_pkg::CAP_W-1:0]  period_ticks,
	output logic [pcdm_pkg::CAP_W-1:0]  on_ticks,
	output logic [pcdm_pkg::DUTY_W-1:0] duty_percent,
	output logic                        zero_period
);

	logic [1:0]                  state_q;
	logic [1:0]                  phase_q;
	logic [pcdm_pkg::CAP_W-1:0]  first_q, second_q, held_q, on_q;
	logic                        nxt_q, meas_q, zp_q;
	logic [pcdm_pkg::REM_W-1:0]  rem_q;
	logic [pcdm_pkg::DIV_W-1:0]  div_q;
	logic [pcdm_pkg::CNT_W-1:0]  cnt_q;
	logic [pcdm_pkg::DUTY_W-1:0] quo_q;
	logic                        out_valid_q;

	logic                        accept;
	logic                        ge;
	logic [pcdm_pkg::DIV_W-1:0]  rem_ext;
	logic [pcdm_pkg::DIV_W-1:0]  diff;

	assign in_stall  = (state_q != pcdm_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// shared compare-subtract unit
	assign rem_ext = {1'b0, rem_q};
	assign ge      = (rem_ext >= div_q);
	assign diff    = rem_ext - div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcdm_pkg::ST_IDLE;
			phase_q     <= pcdm_pkg::PH_FIRST;
			first_q     <= '0;
			second_q    <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == pcdm_pkg::ST_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				pcdm_pkg::ST_IDLE: begin
					if (accept) begin
						unique case (phase_q)
							pcdm_pkg::PH_SECOND: begin
								second_q <= capture_value;
								held_q   <= capture_value - first_q;
								phase_q  <= pcdm_pkg::PH_FALL;
								state_q  <= pcdm_pkg::ST_DONE;
							end
							pcdm_pkg::PH_FALL: begin
								phase_q <= pcdm_pkg::PH_FIRST;
								state_q <= pcdm_pkg::ST_MUL;
							end
							default: begin
								first_q <= capture_value;
								phase_q <= pcdm_pkg::PH_SECOND;
								state_q <= pcdm_pkg::ST_DONE;
							end
						endcase
					end
				end
				pcdm_pkg::ST_MUL: begin
					state_q <= zp_q ? pcdm_pkg::ST_DONE : pcdm_pkg::ST_DIV;
				end
				pcdm_pkg::ST_DIV: begin
					if ((cnt_q == pcdm_pkg::SAT_STEP && ge) || cnt_q == '0)
						state_q <= pcdm_pkg::ST_DONE;
				end
				pcdm_pkg::ST_DONE: begin
					if (!out_valid_q || !out_stall)
						state_q <= pcdm_pkg::ST_IDLE;
				end
				default: state_q <= pcdm_pkg::ST_IDLE;
			endcase
		end
	end

	// working and result data
	always_ff @(posedge clk) begin
		unique case (state_q)
			pcdm_pkg::ST_IDLE: begin
				if (accept) begin
					quo_q <= '0;
					cnt_q <= pcdm_pkg::SAT_STEP;
					unique case (phase_q)
						pcdm_pkg::PH_SECOND: begin
							nxt_q  <= 1'b1;
							meas_q <= 1'b0;
							zp_q   <= 1'b0;
						end
						pcdm_pkg::PH_FALL: begin
							nxt_q  <= 1'b0;
							meas_q <= 1'b1;
							on_q   <= capture_value - second_q;
							zp_q   <= (held_q == '0);
						end
						default: begin
							nxt_q  <= 1'b0;
							meas_q <= 1'b0;
							zp_q   <= 1'b0;
						end
					endcase
				end
			end
			pcdm_pkg::ST_MUL: begin
				rem_q <= pcdm_pkg::REM_W'({7'd0, on_q} * {16'd0, pcdm_pkg::DUTY_SCALE});
				div_q <= {held_q, {pcdm_pkg::DUTY_W{1'b0}}};
			end
			pcdm_pkg::ST_DIV: begin
				if (cnt_q == pcdm_pkg::SAT_STEP) begin
					if (ge)
						quo_q <= pcdm_pkg::DUTY_MAX;
				end else begin
					quo_q <= {quo_q[pcdm_pkg::DUTY_W-2:0], ge};
					if (ge)
						rem_q <= diff[pcdm_pkg::REM_W-1:0];
				end
				div_q <= div_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			pcdm_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					next_edge_falling <= nxt_q;
					measurement_valid <= meas_q;
					period_ticks      <= meas_q ? held_q : '0;
					on_ticks          <= meas_q ? on_q : '0;
					duty_percent      <= quo_q;
					zero_period       <= zp_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/pcdm_checker.sv
// pcdm_checker: port-level assertions for pwm_capture_duty_meter, with bind.
// Depends on pcdm_pkg.
`timescale 1ns / 1ps

module pcdm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        next_edge_falling,
	input logic                        measurement_valid,
	input logic [pcdm_pkg::CAP_W-1:0]  period_ticks,
	input logic [pcdm_pkg::CAP_W-1:0]  on_ticks,
	input logic [pcdm_pkg::DUTY_W-1:0] duty_percent,
	input logic                        zero_period
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty_percent))
		else $error("output word dropped or changed while stalled");

	a_no_meas_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !measurement_valid |->
			period_ticks == '0 && on_ticks == '0 && duty_percent == '0 && !zero_period)
		else $error("non-measurement word carries data");

	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_period |->
			measurement_valid && period_ticks == '0 && duty_percent == '0)
		else $error("zero period word inconsistent");

	a_meas_next_rise: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && measurement_valid |-> !next_edge_falling)
		else $error("measurement word must request a rising edge next");

endmodule

bind pwm_capture_duty_meter pcdm_checker u_pcdm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.next_edge_falling (next_edge_falling),
	.measurement_valid (measurement_valid),
	.period_ticks      (period_ticks),
	.on_ticks          (on_ticks),
	.duty_percent      (duty_percent),
	.zero_period       (zero_period)
);
